@@ hw/rtl/upc_pkg.sv @@
// upc_pkg: shared types, character codes and helper functions for the
// URL percent codec. No dependencies.
package upc_pkg;

  localparam logic [7:0] CH_PCT      = 8'h25;  // '%'
  localparam logic [7:0] CH_PLUS     = 8'h2B;  // '+'
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_UNDER    = 8'h5F;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_0        = 8'h30;
  localparam logic [7:0] CH_9        = 8'h39;
  localparam logic [7:0] CH_UA       = 8'h41;
  localparam logic [7:0] CH_UF       = 8'h46;
  localparam logic [7:0] CH_UZ       = 8'h5A;
  localparam logic [7:0] CH_LA       = 8'h61;
  localparam logic [7:0] CH_LF       = 8'h66;
  localparam logic [7:0] CH_LZ       = 8'h7A;
  localparam logic [7:0] HEX_LC_OFS  = CH_LA - 8'd10;  // 87
  localparam logic [7:0] HEX_UC_OFS  = 8'd55;
  localparam logic [3:0] NIB_MASK    = 4'hF;

  // configuration register indexes
  localparam logic [1:0] REG_ENCODE_MODE  = 2'd0;
  localparam logic [1:0] REG_FORM_FLAVOUR = 2'd1;
  localparam logic [1:0] REG_KEEP_SPACE   = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  // up to three result bytes produced by one input beat
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
    logic       str_end;
  } upc_group_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] n8;
    n8 = {4'h0, n & NIB_MASK};
    return (n < 4'd10) ? (n8 + CH_0) : (n8 + HEX_LC_OFS);
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= CH_0 && c <= CH_9)       d = c - CH_0;
    else if (c >= CH_UA && c <= CH_UF) d = c - HEX_UC_OFS;
    else if (c >= CH_LA && c <= CH_LF) d = c - HEX_LC_OFS;
    return d[3:0];
  endfunction

  function automatic logic unreserved(input logic [7:0] b);
    return (b >= CH_UA && b <= CH_UZ) || (b >= CH_LA && b <= CH_LZ) ||
           (b >= CH_0 && b <= CH_9) ||
           b == CH_DASH || b == CH_UNDER || b == CH_DOT || b == CH_TILDE;
  endfunction

endpackage

@@ hw/rtl/upc_core.sv @@
// upc_core: configuration registers, decode escape state and the
// per-beat translation into a result group. Depends on upc_pkg.
module upc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic               cfg_wdata,
  input  logic               acc,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output upc_pkg::upc_group_t grp
);
  import upc_pkg::*;

  logic       encode_mode_r, encode_mode_nxt;
  logic       form_flavour_r, form_flavour_nxt;
  logic       keep_space_r, keep_space_nxt;
  phase_t     phase_r, phase_nxt;
  logic [3:0] high_nibble_r, high_nibble_nxt;

  always_comb begin
    encode_mode_nxt  = encode_mode_r;
    form_flavour_nxt = form_flavour_r;
    keep_space_nxt   = keep_space_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ENCODE_MODE:  encode_mode_nxt  = cfg_wdata;
        REG_FORM_FLAVOUR: form_flavour_nxt = cfg_wdata;
        REG_KEEP_SPACE:   keep_space_nxt   = cfg_wdata;
        default: ;
      endcase
    end
  end

  // translation of one beat
  always_comb begin
    logic [3:0] nib;
    nib             = nibble_of(in_byte);
    grp.cnt         = 2'd1;
    grp.b0          = in_byte;
    grp.b1          = hex_digit(in_byte[7:4]);
    grp.b2          = hex_digit(in_byte[3:0]);
    grp.str_end     = in_last;
    phase_nxt       = PH_IDLE;
    high_nibble_nxt = high_nibble_r;
    if (encode_mode_r) begin
      if (unreserved(in_byte) || (!form_flavour_r && in_byte == CH_SLASH)) begin
        grp.b0 = in_byte;
      end else if (in_byte == CH_SPACE && form_flavour_r) begin
        grp.b0 = CH_PLUS;
      end else if (in_byte == CH_SPACE && keep_space_r) begin
        grp.b0 = CH_SPACE;
      end else begin
        grp.cnt = 2'd3;
        grp.b0  = CH_PCT;
      end
    end else begin
      case (phase_r)
        PH_HIGH: begin
          grp.cnt         = 2'd0;
          high_nibble_nxt = nib;
          phase_nxt       = in_last ? PH_IDLE : PH_LOW;
        end
        PH_LOW: begin
          grp.b0 = {high_nibble_r, nib};
        end
        default: begin
          if (in_byte == CH_PCT) begin
            grp.cnt   = 2'd0;
            phase_nxt = in_last ? PH_IDLE : PH_HIGH;
          end else if (in_byte == CH_PLUS && form_flavour_r) begin
            grp.b0 = CH_SPACE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      encode_mode_r  <= 1'b0;
      form_flavour_r <= 1'b1;
      keep_space_r   <= 1'b0;
      phase_r        <= PH_IDLE;
      high_nibble_r  <= 4'h0;
    end else begin
      encode_mode_r  <= encode_mode_nxt;
      form_flavour_r <= form_flavour_nxt;
      keep_space_r   <= keep_space_nxt;
      if (acc) begin
        phase_r       <= phase_nxt;
        high_nibble_r <= high_nibble_nxt;
      end
    end
  end

  a_enc_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
    acc && encode_mode_r |=> phase_r == PH_IDLE)
    else $error("escape state left pending after encode beat");

  a_last_ends_escape: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_last |=> phase_r == PH_IDLE)
    else $error("escape carried across string end");

endmodule

@@ hw/rtl/upc_emit.sv @@
// upc_emit: holds one result group and serializes it onto the output
// channel one byte per beat. Depends on upc_pkg.
module upc_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                grp_valid,
  output logic                grp_ready,
  input  upc_pkg::upc_group_t grp,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic                out_string_end
);
  import upc_pkg::*;

  upc_group_t grp_r, grp_nxt;
  logic       valid_r, valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       at_last;

  assign at_last   = (idx_r == grp_r.cnt - 2'd1);
  // accept a group when idle or as the held group's last byte leaves
  assign grp_ready = !valid_r || (out_ready && at_last);

  always_comb begin
    grp_nxt   = grp_r;
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (grp_valid && grp_ready) begin
      grp_nxt   = grp;
      valid_nxt = (grp.cnt != 2'd0);
      idx_nxt   = 2'd0;
    end else if (valid_r && out_ready) begin
      if (at_last) valid_nxt = 1'b0;
      else         idx_nxt   = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    case (idx_r)
      2'd0:    out_byte = grp_r.b0;
      2'd1:    out_byte = grp_r.b1;
      default: out_byte = grp_r.b2;
    endcase
  end

  assign out_valid      = valid_r;
  assign out_last       = at_last;
  assign out_string_end = grp_r.str_end;

  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (grp_r.cnt != 2'd0) && (idx_r < grp_r.cnt))
    else $error("byte index outside held group");

  a_group_continues: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_ready && !at_last |=> valid_r && idx_r == $past(idx_r) + 2'd1)
    else $error("group cut short");

endmodule

@@ hw/rtl/url_percent_codec.sv @@
// url_percent_codec: top level of the streaming URL percent encoder/decoder.
// Depends on upc_pkg, upc_core, upc_emit.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid in_ready in_byte in_last       | sink
//   out     | out_valid out_ready out_byte out_last   | source
//           | out_string_end                          |
//   cfg     | cfg_we cfg_index cfg_wdata              | write only
//
// Each input beat is translated into a group of 0, 1 or 3 bytes
// held in the output register. The single output port sets the rate: an
// escaped byte in encode mode leaves as three bytes, others as one or none.
// The next input beat is taken in the cycle the last byte of a group leaves.
// Reset is synchronous; it restores config defaults and clears the escape
// state. A stalled output holds its byte and stalls the input.
module url_percent_codec (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_string_end
);
  import upc_pkg::*;

  upc_group_t grp;
  logic       acc;

  assign acc = in_valid && in_ready;

  upc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .grp       (grp)
  );

  upc_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .grp_valid      (in_valid),
    .grp_ready      (in_ready),
    .grp            (grp),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_string_end (out_string_end)
  );

endmodule
